// ===== src/mi3_pkg.sv =====
// mi3_pkg: shared types and constants for the 3x3 matrix inverse
// cofactor index table, determinant cofactor list, element and row counts, lane status struct
// no dependencies
`default_nettype none
package mi3_pkg;

	localparam int NUM_ELEM = 9;
	localparam int ROW_LEN  = 3;

	// adj[i] = a[p]*a[q] - a[r]*a[s], row-major element indexes {p, q, r, s}
	localparam int ADJ_IDX [NUM_ELEM][4] = '{
		'{4, 8, 5, 7},
		'{2, 7, 1, 8},
		'{1, 5, 2, 4},
		'{5, 6, 3, 8},
		'{0, 8, 2, 6},
		'{2, 3, 0, 5},
		'{3, 7, 4, 6},
		'{1, 6, 0, 7},
		'{0, 4, 1, 3}
	};

	// adjugate entries that pair with row 0 in the determinant expansion
	localparam int DET_COF [ROW_LEN] = '{0, 3, 6};

	typedef struct packed {
		logic zero;
		logic sat;
	} lane_stat_t;

endpackage
`default_nettype wire

// ===== src/matrix_inverse_3x3.sv =====
// matrix_inverse_3x3: top level, 3x3 fixed-point inverse by adjugate
// uses mi3_pkg, mi3_adj, mi3_det and nine mi3_div lanes
//
// channel  dir  transaction content
// s_axis   in   tdata: a00..a22, DATA_WIDTH bits each, row-major, zero padded
// m_axis   out  tdata: inv00..inv22 row-major, zero padded; tuser: singular, saturated
//
// one matrix per cycle sustained while the output is not stalled; the pipeline depth
// is dominated by the one-bit-per-stage division lanes
// the whole pipeline advances together when the output register is empty or taken
// a stalled output holds every stage; reset clears only the valid bits
`default_nettype none
module matrix_inverse_3x3
	import mi3_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [((NUM_ELEM*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata, // a00..a22
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [((NUM_ELEM*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata, // inv00..inv22
	output logic [1:0]                 m_axis_tuser  // singular, saturated
);

	localparam int D     = DATA_WIDTH;
	localparam int BUS_W = ((NUM_ELEM*D+7)/8)*8;
	localparam int LAT   = D + 9;

	logic                    en;
	logic [LAT-1:0]          vld_q;
	logic signed [D-1:0]     a_s1    [NUM_ELEM];
	logic signed [D-1:0]     row_s3  [ROW_LEN];
	logic signed [2*D:0]     adj_s3  [NUM_ELEM];
	logic signed [2*D:0]     adj_s6  [NUM_ELEM];
	logic signed [3*D+2:0]   det_s6;
	logic [D-1:0]            lane_val  [NUM_ELEM];
	lane_stat_t              lane_stat [NUM_ELEM];
	logic [D-1:0]            inv_q   [NUM_ELEM];
	logic                    sing_q;
	logic                    sat_q;
	logic                    sat_any;

	assign en            = ~vld_q[LAT-1] | m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end

	for (genvar i = 0; i < NUM_ELEM; i++) begin : g_in
		always_ff @(posedge clk) begin
			if (en) begin
				a_s1[i] <= s_axis_tdata[i*D +: D];
			end
		end
	end

	mi3_adj #(.DATA_WIDTH(D)) u_adj (
		.clk     (clk),
		.en      (en),
		.a_in    (a_s1),
		.row_out (row_s3),
		.adj_out (adj_s3)
	);

	mi3_det #(.DATA_WIDTH(D)) u_det (
		.clk     (clk),
		.en      (en),
		.row_in  (row_s3),
		.adj_in  (adj_s3),
		.det_out (det_s6),
		.adj_out (adj_s6)
	);

	for (genvar i = 0; i < NUM_ELEM; i++) begin : g_lane
		mi3_div #(.DATA_WIDTH(D), .FRAC_BITS(FRAC_BITS)) u_div (
			.clk    (clk),
			.en     (en),
			.adj_in (adj_s6[i]),
			.det_in (det_s6),
			.val    (lane_val[i]),
			.stat   (lane_stat[i])
		);
	end

	always_comb begin
		sat_any = 1'b0;
		for (int i = 0; i < NUM_ELEM; i++) begin
			sat_any = sat_any | lane_stat[i].sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_q  <= lane_val;
			sing_q <= lane_stat[0].zero;
			sat_q  <= sat_any;
		end
	end

	for (genvar i = 0; i < NUM_ELEM; i++) begin : g_out
		assign m_axis_tdata[i*D +: D] = inv_q[i];
	end
	if (BUS_W > NUM_ELEM*D) begin : g_pad
		assign m_axis_tdata[BUS_W-1:NUM_ELEM*D] = '0;
	end

	assign m_axis_tuser = {sat_q, sing_q};

endmodule
`default_nettype wire

// ===== src/mi3_adj.sv =====
// mi3_adj: adjugate of a 3x3 matrix, products then differences (two stages)
// uses mi3_pkg for the cofactor index table
`default_nettype none
module mi3_adj
	import mi3_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [DATA_WIDTH-1:0]  a_in    [NUM_ELEM],
	output logic signed [DATA_WIDTH-1:0]       row_out [ROW_LEN],
	output logic signed [2*DATA_WIDTH:0]       adj_out [NUM_ELEM]
);

	localparam int D = DATA_WIDTH;

	logic signed [2*D-1:0] pa_s2  [NUM_ELEM];
	logic signed [2*D-1:0] pb_s2  [NUM_ELEM];
	logic signed [2*D:0]   adj_s3 [NUM_ELEM];
	logic signed [D-1:0]   row_s2 [ROW_LEN];
	logic signed [D-1:0]   row_s3 [ROW_LEN];

	for (genvar i = 0; i < NUM_ELEM; i++) begin : g_cof
		always_ff @(posedge clk) begin
			if (en) begin
				pa_s2[i]  <= a_in[ADJ_IDX[i][0]] * a_in[ADJ_IDX[i][1]];
				pb_s2[i]  <= a_in[ADJ_IDX[i][2]] * a_in[ADJ_IDX[i][3]];
				adj_s3[i] <= {pa_s2[i][2*D-1], pa_s2[i]} - {pb_s2[i][2*D-1], pb_s2[i]};
			end
		end
		assign adj_out[i] = adj_s3[i];
	end

	for (genvar j = 0; j < ROW_LEN; j++) begin : g_row
		always_ff @(posedge clk) begin
			if (en) begin
				row_s2[j] <= a_in[j];
				row_s3[j] <= row_s2[j];
			end
		end
		assign row_out[j] = row_s3[j];
	end

endmodule
`default_nettype wire

// ===== src/mi3_det.sv =====
// mi3_det: determinant by expansion along row 0, split partial products (three stages)
// uses mi3_pkg; also delays the adjugate to line up with the determinant
`default_nettype none
module mi3_det
	import mi3_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [DATA_WIDTH-1:0]  row_in  [ROW_LEN],
	input  wire logic signed [2*DATA_WIDTH:0]  adj_in  [NUM_ELEM],
	output logic signed [3*DATA_WIDTH+2:0]     det_out,
	output logic signed [2*DATA_WIDTH:0]       adj_out [NUM_ELEM]
);

	localparam int D  = DATA_WIDTH;
	localparam int AW = 2*D + 1;
	localparam int TW = 3*D + 1;
	localparam int DW = 3*D + 3;

	logic signed [2*D:0]   ph_s4   [ROW_LEN];
	logic signed [2*D:0]   pl_s4   [ROW_LEN];
	logic signed [TW-1:0]  term_s5 [ROW_LEN];
	logic signed [DW-1:0]  det_s6;
	logic signed [AW-1:0]  adj_s4  [NUM_ELEM];
	logic signed [AW-1:0]  adj_s5  [NUM_ELEM];
	logic signed [AW-1:0]  adj_s6  [NUM_ELEM];

	for (genvar j = 0; j < ROW_LEN; j++) begin : g_term
		logic signed [D:0] hi;
		logic signed [D:0] lo;
		assign hi = adj_in[DET_COF[j]][AW-1:D];
		assign lo = {1'b0, adj_in[DET_COF[j]][D-1:0]};
		always_ff @(posedge clk) begin
			if (en) begin
				ph_s4[j]   <= row_in[j] * hi;
				pl_s4[j]   <= row_in[j] * lo;
				term_s5[j] <= {ph_s4[j], {D{1'b0}}} + {{D{pl_s4[j][2*D]}}, pl_s4[j]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s6 <= {{2{term_s5[0][TW-1]}}, term_s5[0]}
			        + {{2{term_s5[1][TW-1]}}, term_s5[1]}
			        + {{2{term_s5[2][TW-1]}}, term_s5[2]};
		end
	end

	for (genvar i = 0; i < NUM_ELEM; i++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				adj_s4[i] <= adj_in[i];
				adj_s5[i] <= adj_s4[i];
				adj_s6[i] <= adj_s5[i];
			end
		end
		assign adj_out[i] = adj_s6[i];
	end

	assign det_out = det_s6;

endmodule
`default_nettype wire

// ===== src/mi3_div.sv =====
// mi3_div: one lane, signed adjugate entry times 2^(2F) over determinant,
// pipelined restoring division one quotient bit per stage, then saturation
// uses mi3_pkg for the lane status struct
`default_nettype none
module mi3_div
	import mi3_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [2*DATA_WIDTH:0]  adj_in,
	input  wire logic signed [3*DATA_WIDTH+2:0] det_in,
	output logic [DATA_WIDTH-1:0]              val,
	output lane_stat_t                         stat
);

	localparam int D   = DATA_WIDTH;
	localparam int AW  = 2*D + 1;
	localparam int DW  = 3*D + 3;
	localparam int NW  = AW + 2*FRAC_BITS;
	localparam int CW  = ((NW > DW + D) ? NW : DW + D) + 1;

	logic [AW-1:0] adj_mag;
	logic [DW-1:0] det_mag;

	logic [CW-1:0] num_s7;
	logic [DW-1:0] den_s7;
	logic          neg_s7;
	logic          zero_s7;

	logic [CW-1:0] rem_q  [D+1];
	logic [DW-1:0] den_q  [D+1];
	logic [D-1:0]  quo_q  [D+1];
	logic          neg_q  [D+1];
	logic          zero_q [D+1];
	logic          ovf_q  [D+1];

	assign adj_mag = adj_in[AW-1] ? (~adj_in + 1'b1) : adj_in;
	assign det_mag = det_in[DW-1] ? (~det_in + 1'b1) : det_in;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s7  <= CW'(adj_mag) << (2*FRAC_BITS);
			den_s7  <= det_mag;
			neg_s7  <= adj_in[AW-1] ^ det_in[DW-1];
			zero_s7 <= (det_in == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= num_s7;
			den_q[0]  <= den_s7;
			quo_q[0]  <= '0;
			neg_q[0]  <= neg_s7;
			zero_q[0] <= zero_s7;
			ovf_q[0]  <= num_s7 >= (CW'(den_s7) << D);
		end
	end

	for (genvar j = 0; j < D; j++) begin : g_bit
		logic [CW:0] trial;
		logic        take;
		assign trial = (CW+1)'(rem_q[j]) - ((CW+1)'(den_q[j]) << (D-1-j));
		assign take  = ~trial[CW];
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j+1]  <= take ? trial[CW-1:0] : rem_q[j];
				den_q[j+1]  <= den_q[j];
				quo_q[j+1]  <= {quo_q[j][D-2:0], take};
				neg_q[j+1]  <= neg_q[j];
				zero_q[j+1] <= zero_q[j];
				ovf_q[j+1]  <= ovf_q[j];
			end
		end
	end

	logic [D-1:0] q;
	logic [D-1:0] pos_max;
	logic [D-1:0] neg_min;

	assign q       = quo_q[D];
	assign pos_max = {1'b0, {(D-1){1'b1}}};
	assign neg_min = {1'b1, {(D-1){1'b0}}};

	always_comb begin
		stat.zero = zero_q[D];
		stat.sat  = 1'b0;
		val       = '0;
		priority if (zero_q[D]) begin
			val = '0;
		end else if (ovf_q[D]) begin
			stat.sat = 1'b1;
			val      = neg_q[D] ? neg_min : pos_max;
		end else if (!neg_q[D]) begin
			stat.sat = q[D-1];
			val      = q[D-1] ? pos_max : q;
		end else begin
			stat.sat = q[D-1] & (|q[D-2:0]);
			val      = stat.sat ? neg_min : (~q + 1'b1);
		end
	end

endmodule
`default_nettype wire
